FILE: rtl/pfra_pkg.sv
// Shared types, codes and constants of the page frame share count allocator.
`default_nettype none
package pfra_pkg;

   localparam int PAGE_W  = 14;
   localparam int COUNT_W = 8;
   localparam int REG_W   = 15;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam int DEFAULT_NUM_PAGES = 16384;

   localparam logic [COUNT_W-1:0] RESERVED_COUNT = 8'd100;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_ONE      = 8'd1;
   localparam logic [COUNT_W-1:0] COUNT_ZERO     = 8'd0;

   localparam logic [REG_W-1:0] OBJ_START_RESET  = 15'd256;
   localparam logic [REG_W-1:0] USER_START_RESET = 15'd1024;
   localparam logic [REG_W-1:0] USER_END_RESET   = 15'd16384;

   // Register indexes, taken from byte address bits [3:2].
   localparam logic [1:0] REG_OBJ_START  = 2'd0;
   localparam logic [1:0] REG_USER_START = 2'd1;
   localparam logic [1:0] REG_USER_END   = 2'd2;

   typedef enum logic [2:0] {
      ACT_ALLOC_USER = 3'd0,
      ACT_ALLOC_OBJ  = 3'd1,
      ACT_SHARE      = 3'd2,
      ACT_FREE       = 3'd3,
      ACT_QUERY      = 3'd4,
      ACT_SET        = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_PROTECTED    = 3'd1,
      ST_ALREADY_FREE = 3'd2,
      ST_NO_FREE      = 3'd3,
      ST_SATURATED    = 3'd4
   } status_type;

   typedef struct packed {
      logic [REG_W-1:0] obj_start;
      logic [REG_W-1:0] user_start;
      logic [REG_W-1:0] user_end;
   } regs_type;

   typedef struct packed {
      logic clear_en;
      logic accept;
      logic scan_en;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic start_alloc;
      logic scan_hit;
      logic scan_miss;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/pfra_csr.sv
// Configuration register bank behind the APB-style port.
`default_nettype none
module pfra_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [pfra_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [pfra_pkg::DATA_W-1:0]  pwdata,
   output logic      [pfra_pkg::DATA_W-1:0]  prdata,
   output pfra_pkg::regs_type                regs
);
   import pfra_pkg::*;

   regs_type regs_ff;
   regs_type regs_in;
   logic     wr_en;

   assign wr_en = psel && penable && pwrite;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_OBJ_START:  regs_in.obj_start  = pwdata[REG_W-1:0];
            REG_USER_START: regs_in.user_start = pwdata[REG_W-1:0];
            REG_USER_END:   regs_in.user_end   = pwdata[REG_W-1:0];
            default:        regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.obj_start  <= OBJ_START_RESET;
         regs_ff.user_start <= USER_START_RESET;
         regs_ff.user_end   <= USER_END_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_OBJ_START:  prdata = {{(DATA_W-REG_W){1'b0}}, regs_ff.obj_start};
         REG_USER_START: prdata = {{(DATA_W-REG_W){1'b0}}, regs_ff.user_start};
         REG_USER_END:   prdata = {{(DATA_W-REG_W){1'b0}}, regs_ff.user_end};
         default:        prdata = '0;
      endcase
   end

   assign regs = regs_ff;

endmodule
`default_nettype wire

FILE: rtl/pfra_ctrl.sv
// Sequencing state machine: clearing pass, accept, scan, finish and result handoff.
`default_nettype none
module pfra_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   input  pfra_pkg::sts_type       sts,
   output pfra_pkg::cmd_type       cmd
);
   import pfra_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // The result slot is free when empty or being taken this cycle.
   always_comb begin
      cmd.clear_en = (state_ff == S_CLEAR);
      cmd.accept   = (state_ff == S_IDLE) && req_tvalid;
      cmd.scan_en  = (state_ff == S_SCAN);
      cmd.commit   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd.accept) state_in = sts.start_alloc ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            if (sts.scan_hit || sts.scan_miss) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)      rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/pfra_datapath.sv
// Share count memory, scan counter, update logic and result registers.
`default_nettype none
module pfra_datapath #(
   parameter int NUM_PAGES = pfra_pkg::DEFAULT_NUM_PAGES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  pfra_pkg::cmd_type                  cmd,
   output pfra_pkg::sts_type                  sts,
   input  pfra_pkg::regs_type                 regs,
   input  wire logic [2:0]                    req_action,
   input  wire logic [pfra_pkg::PAGE_W-1:0]   req_page,
   input  wire logic [pfra_pkg::COUNT_W-1:0]  req_set_value,
   output logic      [pfra_pkg::PAGE_W-1:0]   rsp_page_out,
   output logic      [pfra_pkg::COUNT_W-1:0]  rsp_count,
   output logic      [2:0]                    rsp_status
);
   import pfra_pkg::*;

   localparam int AW = $clog2(NUM_PAGES);

   logic [COUNT_W-1:0] mem [NUM_PAGES];

   // Captured request.
   action_type         action_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [COUNT_W-1:0] value_ff;

   // Scan state.
   logic [REG_W-1:0]   scan_ff, scan_in;
   logic [REG_W-1:0]   end_ff, end_in;
   logic [REG_W-1:0]   rd_page_ff;
   logic               rd_pend_ff, rd_pend_in;
   logic               found_ff;
   logic [REG_W-1:0]   lo, hi;
   logic               issue;

   // Clearing pass counter.
   logic [AW-1:0]      clr_ff;

   // Memory ports.
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [COUNT_W-1:0] rd_data_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [COUNT_W-1:0] wr_data;

   // Finish stage.
   logic               page_valid;
   logic               protected_page;
   logic [COUNT_W-1:0] cur;
   logic               upd_en;
   logic [AW-1:0]      upd_addr;
   logic [COUNT_W-1:0] upd_value;
   logic [PAGE_W-1:0]  res_page;
   logic [COUNT_W-1:0] res_count;
   status_type         res_status;

   logic [PAGE_W-1:0]  rsp_page_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   status_type         rsp_status_ff;

   assign sts.start_alloc = (req_action == ACT_ALLOC_USER) || (req_action == ACT_ALLOC_OBJ);
   assign sts.clear_last  = cmd.clear_en && (clr_ff == AW'(NUM_PAGES - 1));
   assign sts.scan_hit    = cmd.scan_en && rd_pend_ff && (rd_data_ff == COUNT_ZERO);
   assign sts.scan_miss   = cmd.scan_en && !rd_pend_ff && !(scan_ff < end_ff);

   // Region bounds; the end is clipped to the size of the store.
   always_comb begin
      if (req_action == ACT_ALLOC_USER) begin
         lo = regs.user_start;
         hi = regs.user_end;
      end else begin
         lo = regs.obj_start;
         hi = regs.user_start;
      end
      if ({17'd0, hi} > 32'(NUM_PAGES)) end_in = REG_W'(NUM_PAGES);
      else                              end_in = hi;
   end

   // One read is issued per scan cycle while pages remain and no hit is seen.
   assign issue = cmd.scan_en && !sts.scan_hit && (scan_ff < end_ff);

   always_comb begin
      scan_in    = scan_ff;
      rd_pend_in = rd_pend_ff;
      if (cmd.accept) begin
         scan_in    = lo;
         rd_pend_in = 1'b0;
      end else if (cmd.scan_en) begin
         rd_pend_in = issue;
         if (issue) scan_in = scan_ff + REG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         found_ff   <= 1'b0;
         clr_ff     <= '0;
      end else begin
         rd_pend_ff <= rd_pend_in;
         if (cmd.accept)        found_ff <= 1'b0;
         else if (sts.scan_hit) found_ff <= 1'b1;
         if (cmd.clear_en)      clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      if (cmd.accept) begin
         action_ff <= action_type'(req_action);
         page_ff   <= req_page;
         value_ff  <= req_set_value;
         end_ff    <= end_in;
      end
      if (issue) rd_page_ff <= scan_ff;
   end

   assign rd_en   = cmd.accept || issue;
   assign rd_addr = cmd.accept ? AW'(req_page) : AW'(scan_ff);

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   assign wr_en   = cmd.clear_en || (cmd.commit && upd_en);
   assign wr_addr = cmd.clear_en ? clr_ff : upd_addr;
   assign wr_data = cmd.clear_en ? RESERVED_COUNT : upd_value;

   assign page_valid     = {18'd0, page_ff} < 32'(NUM_PAGES);
   assign protected_page = !page_valid || ({1'b0, page_ff} < regs.obj_start);
   assign cur            = page_valid ? rd_data_ff : COUNT_ZERO;

   always_comb begin
      upd_en     = 1'b0;
      upd_addr   = AW'(page_ff);
      upd_value  = cur;
      res_page   = page_ff;
      res_count  = cur;
      res_status = ST_OK;
      unique case (action_ff)
         ACT_ALLOC_USER, ACT_ALLOC_OBJ: begin
            upd_addr = AW'(rd_page_ff);
            if (found_ff) begin
               upd_en    = 1'b1;
               upd_value = COUNT_ONE;
               res_page  = rd_page_ff[PAGE_W-1:0];
               res_count = COUNT_ONE;
            end else begin
               res_page   = '0;
               res_count  = COUNT_ZERO;
               res_status = ST_NO_FREE;
            end
         end
         ACT_SHARE: begin
            priority if (protected_page) begin
               res_status = ST_PROTECTED;
            end else if (cur == COUNT_MAX) begin
               res_status = ST_SATURATED;
            end else begin
               upd_en    = 1'b1;
               upd_value = cur + COUNT_ONE;
               res_count = cur + COUNT_ONE;
            end
         end
         ACT_FREE: begin
            priority if (protected_page) begin
               res_status = ST_PROTECTED;
            end else if (cur == COUNT_ZERO) begin
               res_status = ST_ALREADY_FREE;
            end else begin
               upd_en    = 1'b1;
               upd_value = cur - COUNT_ONE;
               res_count = cur - COUNT_ONE;
            end
         end
         ACT_SET: begin
            if (page_valid) begin
               upd_en    = 1'b1;
               upd_value = value_ff;
               res_count = value_ff;
            end else begin
               res_count = COUNT_ZERO;
            end
         end
         default: begin
            res_count = cur;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_page_ff   <= res_page;
         rsp_count_ff  <= res_count;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_page_out = rsp_page_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
`default_nettype wire

FILE: rtl/page_frame_refcount_allocator.sv
// Top level of the page frame allocator with per-page share counts.
//
// This block keeps an 8-bit share count for each of NUM_PAGES page frames in
// a single-port-read, single-port-write memory. After reset it runs a clearing
// pass that writes the reserved count (100) into every entry, one entry per
// cycle, so it accepts no transaction until that pass is done; the
// configuration port works during that time. An allocation transaction scans
// its region one memory entry per clock for the first page whose count is
// zero, a pace set by that single memory read port, and stops at the end of
// the region with no-free status if none is found. Share, free, query and set
// entry take one memory read and at most one update (query writes nothing):
// the read is issued at acceptance, the finish state loads the result
// register once the output slot is free, and only then is the next
// transaction accepted. One transaction is worked on at a time, while the
// previous result may still wait in the output register.
// Configuration must be written only while the block is idle.
`default_nettype none
module page_frame_refcount_allocator #(
   parameter int NUM_PAGES = pfra_pkg::DEFAULT_NUM_PAGES
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Request channel.
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [23:0]                  req_tdata,  // page[13:0], set_value[21:14], zero pad
   input  wire logic [2:0]                   req_tuser,  // action[2:0]
   // Response channel.
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [23:0]                  rsp_tdata,  // page_out[13:0], count[21:14], zero pad
   output logic      [2:0]                   rsp_tuser,  // status[2:0]
   // Configuration port.
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [pfra_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [pfra_pkg::DATA_W-1:0]  csr_pwdata,
   output logic      [pfra_pkg::DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import pfra_pkg::*;

   regs_type           regs;
   cmd_type            cmd;
   sts_type            sts;
   logic [PAGE_W-1:0]  rsp_page_out;
   logic [COUNT_W-1:0] rsp_count;
   logic [2:0]         rsp_status;

   // The register port never stalls.
   assign csr_pready = 1'b1;

   pfra_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .regs    (regs)
   );

   // The controller sequences each transaction; the datapath holds the memory.
   pfra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pfra_datapath #(
      .NUM_PAGES (NUM_PAGES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .regs          (regs),
      .req_action    (req_tuser),
      .req_page      (req_tdata[13:0]),
      .req_set_value (req_tdata[21:14]),
      .rsp_page_out  (rsp_page_out),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   assign rsp_tdata = {2'b00, rsp_count, rsp_page_out};
   assign rsp_tuser = rsp_status;

endmodule
`default_nettype wire
